// File: rtl/iec_pkg.sv
package iec_pkg;

  // event kinds carried on the op field
  typedef enum logic [1:0] {
    OP_DISTANCE = 2'd0,
    OP_TOUCH    = 2'd1,
    OP_IDLE     = 2'd2,
    OP_RESTART  = 2'd3
  } op_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_RANGE_LIMIT  = 3'd0,
    REG_TOO_CLOSE    = 3'd1,
    REG_APPROACH     = 3'd2,
    REG_SPIKE        = 3'd3,
    REG_TOUCH_WINDOW = 3'd4,
    REG_BURST_COUNT  = 3'd5,
    REG_SAD_IDLE     = 3'd6,
    REG_SLEEPY_IDLE  = 3'd7
  } reg_idx_t;

  // nudge kinds, each maps to a fixed (valence, arousal) pair
  typedef enum logic [2:0] {
    NUDGE_STARTLE  = 3'd0,
    NUDGE_APPROACH = 3'd1,
    NUDGE_THREAT   = 3'd2,
    NUDGE_PET      = 3'd3,
    NUDGE_BURST    = 3'd4,
    NUDGE_SAD      = 3'd5,
    NUDGE_SLEEPY   = 3'd6
  } nudge_t;

  // one queue word: an event with one or two nudges
  typedef struct packed {
    logic   two;
    nudge_t first;
    nudge_t second;
  } queue_entry_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  localparam logic [9:0]  RANGE_LIMIT_RST  = 10'd200;
  localparam logic [9:0]  TOO_CLOSE_RST    = 10'd10;
  localparam logic [9:0]  APPROACH_RST     = 10'd4;
  localparam logic [9:0]  SPIKE_RST        = 10'd20;
  localparam logic [15:0] TOUCH_WINDOW_RST = 16'd2000;
  localparam logic [3:0]  BURST_COUNT_RST  = 4'd3;
  localparam logic [31:0] SAD_IDLE_RST     = 32'd30000;
  localparam logic [31:0] SLEEPY_IDLE_RST  = 32'd60000;

  function automatic logic signed [5:0] nudge_valence(input nudge_t n);
    logic signed [5:0] v;
    case (n)
      NUDGE_STARTLE:  v = -6'sd4;
      NUDGE_APPROACH: v = 6'sd2;
      NUDGE_THREAT:   v = -6'sd10;
      NUDGE_PET:      v = 6'sd12;
      NUDGE_BURST:    v = 6'sd30;
      NUDGE_SAD:      v = -6'sd2;
      NUDGE_SLEEPY:   v = 6'sd0;
      default:        v = 6'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [6:0] nudge_arousal(input nudge_t n);
    logic signed [6:0] a;
    case (n)
      NUDGE_STARTLE:  a = 7'sd48;
      NUDGE_APPROACH: a = 7'sd10;
      NUDGE_THREAT:   a = 7'sd12;
      NUDGE_PET:      a = 7'sd4;
      NUDGE_BURST:    a = 7'sd0;
      NUDGE_SAD:      a = 7'sd0;
      NUDGE_SLEEPY:   a = -7'sd3;
      default:        a = 7'sd0;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/iec_front.sv
module iec_front
  import iec_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            op,
  input  logic [9:0]            distance_cm,
  input  logic [31:0]           now_ms,
  input  logic                  q_full,
  output logic                  q_push,
  output queue_entry_t          q_entry
);

  // configuration
  logic [9:0]  range_limit;
  logic [9:0]  too_close;
  logic [9:0]  approach_step;
  logic [9:0]  spike_step;
  logic [15:0] touch_window;
  logic [3:0]  burst_count;
  logic [31:0] sad_idle;
  logic [31:0] sleepy_idle;

  // event state
  logic [9:0]  prev_distance;
  logic        prev_valid;
  logic [31:0] last_activity;
  logic [3:0]  touch_counter;
  logic [31:0] window_start;

  logic               accept;
  op_t                op_kind;
  logic               in_range;
  logic signed [10:0] decrease;
  logic               spike_hit;
  logic               approach_hit;
  logic               close_hit;
  logic [31:0]        touch_elapsed;
  logic               window_expired;
  logic [3:0]         count_base;
  logic [3:0]         count_inc;
  logic               burst_hit;
  logic [31:0]        idle_time;
  logic               sad_hit;
  logic               sleepy_hit;
  logic               a_valid;
  logic               b_valid;
  nudge_t             a_code;
  nudge_t             b_code;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign op_kind  = op_t'(op);

  // distance checks
  assign in_range     = distance_cm <= range_limit;
  assign decrease     = $signed({1'b0, prev_distance}) - $signed({1'b0, distance_cm});
  assign spike_hit    = decrease >= $signed({1'b0, spike_step});
  assign approach_hit = decrease >= $signed({1'b0, approach_step});
  assign close_hit    = distance_cm <= too_close;

  // touch window, 32-bit wrap on the elapsed time
  assign touch_elapsed  = now_ms - window_start;
  assign window_expired = touch_elapsed > {16'd0, touch_window};
  assign count_base     = window_expired ? 4'd0 : touch_counter;
  assign count_inc      = count_base + 4'd1;
  assign burst_hit      = count_inc >= burst_count;

  // idle limits
  assign idle_time  = now_ms - last_activity;
  assign sad_hit    = idle_time >= sad_idle;
  assign sleepy_hit = idle_time >= sleepy_idle;

  // up to two nudges per event, first slot packed first
  always_comb begin
    a_valid = 1'b0;
    b_valid = 1'b0;
    a_code  = NUDGE_PET;
    b_code  = NUDGE_BURST;
    case (op_kind)
      OP_DISTANCE: begin
        a_valid = in_range && prev_valid && (spike_hit || approach_hit);
        a_code  = spike_hit ? NUDGE_STARTLE : NUDGE_APPROACH;
        b_valid = in_range && prev_valid && close_hit;
        b_code  = NUDGE_THREAT;
      end
      OP_TOUCH: begin
        a_valid = 1'b1;
        a_code  = NUDGE_PET;
        b_valid = burst_hit;
        b_code  = NUDGE_BURST;
      end
      OP_IDLE: begin
        a_valid = sad_hit;
        a_code  = NUDGE_SAD;
        b_valid = sleepy_hit;
        b_code  = NUDGE_SLEEPY;
      end
      default: begin
        a_valid = 1'b0;
        b_valid = 1'b0;
      end
    endcase
  end

  assign q_push         = accept && (a_valid || b_valid);
  assign q_entry.two    = a_valid && b_valid;
  assign q_entry.first  = a_valid ? a_code : b_code;
  assign q_entry.second = b_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_limit   <= RANGE_LIMIT_RST;
      too_close     <= TOO_CLOSE_RST;
      approach_step <= APPROACH_RST;
      spike_step    <= SPIKE_RST;
      touch_window  <= TOUCH_WINDOW_RST;
      burst_count   <= BURST_COUNT_RST;
      sad_idle      <= SAD_IDLE_RST;
      sleepy_idle   <= SLEEPY_IDLE_RST;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_RANGE_LIMIT:  range_limit   <= cfg_data[9:0];
        REG_TOO_CLOSE:    too_close     <= cfg_data[9:0];
        REG_APPROACH:     approach_step <= cfg_data[9:0];
        REG_SPIKE:        spike_step    <= cfg_data[9:0];
        REG_TOUCH_WINDOW: touch_window  <= cfg_data[15:0];
        REG_BURST_COUNT:  burst_count   <= cfg_data[3:0];
        REG_SAD_IDLE:     sad_idle      <= cfg_data[31:0];
        REG_SLEEPY_IDLE:  sleepy_idle   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_distance <= 10'd0;
      prev_valid    <= 1'b0;
      last_activity <= 32'd0;
      touch_counter <= 4'd0;
      window_start  <= 32'd0;
    end else if (accept) begin
      case (op_kind)
        OP_DISTANCE: begin
          if (in_range) begin
            last_activity <= now_ms;
            prev_distance <= distance_cm;
            prev_valid    <= 1'b1;
          end else begin
            prev_valid <= 1'b0;
          end
        end
        OP_TOUCH: begin
          last_activity <= now_ms;
          if (burst_hit) begin
            touch_counter <= 4'd0;
            window_start  <= now_ms;
          end else begin
            touch_counter <= count_inc;
            if (window_expired) begin
              window_start <= now_ms;
            end
          end
        end
        OP_IDLE: ;
        default: begin
          prev_distance <= 10'd0;
          prev_valid    <= 1'b0;
          last_activity <= now_ms;
          touch_counter <= 4'd0;
          window_start  <= now_ms;
        end
      endcase
    end
  end

endmodule

// File: rtl/iec_queue.sv
module iec_queue
  import iec_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  queue_entry_t push_entry,
  input  logic         pop,
  output queue_entry_t head,
  output logic         empty,
  output logic         full
);

  queue_entry_t       mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;

  assign empty = count == '0;
  assign full  = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/iec_back.sv
module iec_back
  import iec_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  queue_entry_t       head,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [5:0]  valence_delta,
  output logic signed [6:0]  arousal_delta,
  output logic               last
);

  logic   load;
  logic   second_sel;
  logic   word_last;
  nudge_t cur;

  // output register takes a new word when empty or being drained
  assign load      = !out_valid || !out_stall;
  assign cur       = second_sel ? head.second : head.first;
  assign word_last = !head.two || second_sel;
  assign q_pop     = load && !q_empty && word_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      second_sel <= 1'b0;
    end else if (load) begin
      out_valid <= !q_empty;
      if (!q_empty) begin
        second_sel <= !word_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      valence_delta <= nudge_valence(cur);
      arousal_delta <= nudge_arousal(cur);
      last          <= word_last;
    end
  end

endmodule

// File: rtl/interaction_event_classifier_core.sv
// First result word of an event: written to the queue when the event is accepted, then
//   loaded into the single output register. One result word per cycle leaves it while
//   out_stall is low; an event with no results pushes nothing, one with two yields two.
// A four-word queue between classifier and output lets input run ahead of a stalled output.
// Reset (rst, synchronous): registers return to defaults, event state is a restart at
//   time 0, queue and output are emptied.
module interaction_event_classifier_core
  import iec_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // config write port
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // event input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            op,
  input  logic [9:0]            distance_cm,
  input  logic [31:0]           now_ms,
  // nudge output
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [5:0]     valence_delta,
  output logic signed [6:0]     arousal_delta,
  output logic                  last
);

  // front -> queue
  logic         q_push;
  queue_entry_t q_entry;
  logic         q_full;
  // queue -> back
  queue_entry_t q_head;
  logic         q_empty;
  logic         q_pop;

  // Front: owns the config and event history, classifies each event as it is
  // accepted and pushes one word per event that produces any nudge.
  iec_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .distance_cm (distance_cm),
    .now_ms      (now_ms),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (q_entry)
  );

  // Queue: decouples the two sides; input stalls only when it fills.
  iec_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty),
    .full       (q_full)
  );

  // Back: expands each queued word into one or two result words, marks the final one.
  iec_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (q_head),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .valence_delta (valence_delta),
    .arousal_delta (arousal_delta),
    .last          (last)
  );

endmodule

// File: rtl/iec_checker.sv
module iec_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic signed [5:0] valence_delta,
  input logic signed [6:0] arousal_delta,
  input logic              last
);

  // a stalled result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(valence_delta)
      && $stable(arousal_delta) && $stable(last))
    else $error("stalled result word changed");

  // every result is one of the known nudge pairs
  a_pair_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (valence_delta == -6'sd4 && arousal_delta == 7'sd48)
      || (valence_delta == 6'sd2 && arousal_delta == 7'sd10)
      || (valence_delta == -6'sd10 && arousal_delta == 7'sd12)
      || (valence_delta == 6'sd12 && arousal_delta == 7'sd4)
      || (valence_delta == 6'sd30 && arousal_delta == 7'sd0)
      || (valence_delta == -6'sd2 && arousal_delta == 7'sd0)
      || (valence_delta == 6'sd0 && arousal_delta == -7'sd3))
    else $error("unknown nudge pair");

  // nudges that can only end an event carry last
  a_tail_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (valence_delta == 6'sd30 || valence_delta == -6'sd10
      || arousal_delta == -7'sd3) |-> last)
    else $error("closing nudge without last");

  // a non-final word is always followed by another word
  a_not_last_follow: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid)
    else $error("event ended without a final word");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind interaction_event_classifier_core iec_checker u_iec_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .valence_delta (valence_delta),
  .arousal_delta (arousal_delta),
  .last          (last)
);
